// ===== hdl/fpagc_pkg.sv =====
// Shared types and constants for the frame peak audio AGC.
package fpagc_pkg;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;      // input beat accepted: read frame store, update peak
    logic emit;      // load output register, write sample back, advance position
    logic hist_wr;   // push frame peak into the history ring
    logic scan_run;  // step the history max scan
    logic div_load;  // start the gain division
    logic div_run;   // one quotient bit
    logic tgt_calc;  // clamp target, form the rising step
    logic gain_upd;  // commit tracked and frame gain
  } fpagc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic frame_last;
    logic out_free;
    logic scan_done;
    logic div_done;
  } fpagc_sts_t;

  localparam int unsigned NUM_W       = 23;
  localparam logic [22:0] GAIN_NUM    = 23'd5871872;  // 22937 in Q8.8
  localparam logic [15:0] GAIN_ZERO   = 16'd12800;
  localparam logic [15:0] GAIN_MIN    = 16'd256;
  localparam logic [15:0] GAIN_MAX    = 16'd51200;
  localparam logic [15:0] GAIN_RESET  = 16'd6400;
  localparam logic [15:0] OUT_LIMIT   = 16'd32760;
  localparam logic [16:0] RECIP10     = 17'd52429;    // 2^19 / 10, rounded up
  localparam int unsigned RECIP10_SH  = 19;

endpackage

// ===== hdl/fpagc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fpagc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 160
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/fpagc_ctrl.sv =====
// Controller state machine: sample handling and the frame-end gain sequence.
module fpagc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  fpagc_pkg::fpagc_sts_t  sts,
  output fpagc_pkg::fpagc_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCALE = 3'd1;
  localparam logic [2:0] ST_HWR   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DLD   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_TGT   = 3'd6;
  localparam logic [2:0] ST_UPD   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // no beat is taken while reset is held
  assign in_ready = !rst && (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take   = 1'b1;
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.frame_last ? ST_HWR : ST_IDLE;
        end
      end
      ST_HWR: begin
        cmd.hist_wr = 1'b1;
        state_next  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_DLD;
        end
      end
      ST_DLD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_run = 1'b1;
        if (sts.div_done) begin
          state_next = ST_TGT;
        end
      end
      ST_TGT: begin
        cmd.tgt_calc = 1'b1;
        state_next   = ST_UPD;
      end
      ST_UPD: begin
        cmd.gain_upd = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/fpagc_dp.sv =====
// Datapath: frame store, peak tracking, history scan, gain division and scaling.
module fpagc_dp #(
  parameter int unsigned FRAME_LEN   = 160,
  parameter int unsigned HISTORY_LEN = 25
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fpagc_pkg::fpagc_cmd_t  cmd,
  output fpagc_pkg::fpagc_sts_t  sts,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [15:0]            manual_gain,
  input  logic signed [15:0]     sample_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [15:0]     sample_out,
  output logic [15:0]            gain_used
);

  localparam int unsigned FW  = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
  localparam int unsigned HW  = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
  localparam int unsigned HCW = $clog2(HISTORY_LEN + 1);
  localparam int unsigned DCW = $clog2(fpagc_pkg::NUM_W + 1);

  // frame side
  logic [FW-1:0]  pos;
  logic           filled;
  logic [15:0]    sample_reg;
  logic [15:0]    running_peak;
  logic [15:0]    in_mag;
  logic [15:0]    frame_rdata;

  // history side
  logic [HW-1:0]  hpos;
  logic [HCW-1:0] hcount;
  logic [HCW-1:0] sidx;
  logic           scan_issue;
  logic           chk;
  logic [15:0]    hist_rdata;
  logic [15:0]    peak_max;

  // division and gain
  logic [22:0]    numr;
  logic [15:0]    rem;
  logic [22:0]    quot;
  logic [DCW-1:0] dcnt;
  logic [16:0]    trial;
  logic [15:0]    target;
  logic [15:0]    target_reg;
  logic           raise;
  logic [32:0]    step_prod;
  logic [15:0]    tracked_gain;
  logic [15:0]    tracked_next;
  logic [15:0]    frame_gain;
  logic [15:0]    manual_reg;

  // scaling
  logic [15:0]    rd_sample;
  logic           rd_neg;
  logic [15:0]    rd_mag;
  logic [31:0]    scaled;
  logic [15:0]    sat_mag;

  fpagc_ram #(.WIDTH(16), .DEPTH(FRAME_LEN)) u_frame_ram (
    .clk   (clk),
    .we    (cmd.emit),
    .waddr (pos),
    .wdata (sample_reg),
    .re    (cmd.take),
    .raddr (pos),
    .rdata (frame_rdata)
  );

  fpagc_ram #(.WIDTH(16), .DEPTH(HISTORY_LEN)) u_hist_ram (
    .clk   (clk),
    .we    (cmd.hist_wr),
    .waddr (hpos),
    .wdata (running_peak),
    .re    (scan_issue),
    .raddr (sidx[HW-1:0]),
    .rdata (hist_rdata)
  );

  assign cfg_ready = !rst;

  // most negative sample gives 32768, which still fits unsigned
  assign in_mag = sample_in[15] ? 16'(~sample_in + 16'sd1) : 16'(sample_in);

  assign sts.frame_last = (pos == FW'(FRAME_LEN - 1));
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.scan_done  = (sidx == HCW'(HISTORY_LEN)) && !chk;
  assign sts.div_done   = (dcnt == '0);

  // unwritten frame entries read as zero during the first frame
  assign rd_sample = filled ? frame_rdata : 16'd0;
  assign rd_neg    = rd_sample[15];
  assign rd_mag    = rd_neg ? 16'(~rd_sample + 16'd1) : rd_sample;
  assign scaled    = 32'(rd_mag) * 32'(frame_gain);
  assign sat_mag   = (scaled[31:8] > 24'(fpagc_pkg::OUT_LIMIT)) ? fpagc_pkg::OUT_LIMIT
                                                                : scaled[23:8];

  assign scan_issue = cmd.scan_run && (sidx < HCW'(HISTORY_LEN));
  assign trial      = {rem, numr[22]};

  always_comb begin
    if (peak_max == 16'd0) begin
      target = fpagc_pkg::GAIN_ZERO;
    end else if (quot > 23'(fpagc_pkg::GAIN_MAX)) begin
      target = fpagc_pkg::GAIN_MAX;
    end else if (quot < 23'(fpagc_pkg::GAIN_MIN)) begin
      target = fpagc_pkg::GAIN_MIN;
    end else begin
      target = quot[15:0];
    end
  end

  assign tracked_next = raise ? 16'(tracked_gain + 16'(step_prod >> fpagc_pkg::RECIP10_SH))
                              : target_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      filled       <= 1'b0;
      running_peak <= 16'd0;
      out_valid    <= 1'b0;
      hpos         <= '0;
      hcount       <= '0;
      sidx         <= '0;
      chk          <= 1'b0;
      dcnt         <= '0;
      tracked_gain <= fpagc_pkg::GAIN_RESET;
      frame_gain   <= fpagc_pkg::GAIN_RESET;
      manual_reg   <= 16'd0;
    end else begin
      if (cfg_valid) begin
        manual_reg <= manual_gain;
      end

      if (cmd.take && (in_mag > running_peak)) begin
        running_peak <= in_mag;
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (sts.frame_last) begin
          pos    <= '0;
          filled <= 1'b1;
        end else begin
          pos <= pos + FW'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.hist_wr) begin
        running_peak <= 16'd0;
        hpos         <= (hpos == HW'(HISTORY_LEN - 1)) ? '0 : hpos + HW'(1);
        if (hcount != HCW'(HISTORY_LEN)) begin
          hcount <= hcount + HCW'(1);
        end
        sidx <= '0;
        chk  <= 1'b0;
      end

      if (cmd.scan_run) begin
        // entries at or past the fill count were never written and are skipped
        chk <= scan_issue && (sidx < hcount);
        if (scan_issue) begin
          sidx <= sidx + HCW'(1);
        end
      end

      if (cmd.div_load) begin
        dcnt <= DCW'(fpagc_pkg::NUM_W);
      end else if (cmd.div_run && (dcnt != '0)) begin
        dcnt <= dcnt - DCW'(1);
      end

      if (cmd.gain_upd) begin
        tracked_gain <= tracked_next;
        frame_gain   <= (manual_reg != 16'd0) ? manual_reg : tracked_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sample_reg <= sample_in;
    end

    if (cmd.emit) begin
      sample_out <= rd_neg ? 16'(-sat_mag) : sat_mag;
      gain_used  <= frame_gain;
    end

    if (cmd.hist_wr) begin
      peak_max <= 16'd0;
    end else if (cmd.scan_run && chk && (hist_rdata > peak_max)) begin
      peak_max <= hist_rdata;
    end

    // restoring division, one quotient bit per cycle
    if (cmd.div_load) begin
      numr <= fpagc_pkg::GAIN_NUM;
      rem  <= 16'd0;
      quot <= 23'd0;
    end else if (cmd.div_run && (dcnt != '0)) begin
      numr <= {numr[21:0], 1'b0};
      if (trial >= {1'b0, peak_max}) begin
        rem  <= 16'(trial - {1'b0, peak_max});
        quot <= {quot[21:0], 1'b1};
      end else begin
        rem  <= trial[15:0];
        quot <= {quot[21:0], 1'b0};
      end
    end

    if (cmd.tgt_calc) begin
      target_reg <= target;
      raise      <= (target > tracked_gain);
      step_prod  <= 33'(16'(target - tracked_gain)) * 33'(fpagc_pkg::RECIP10);
    end
  end

endmodule

// ===== hdl/frame_peak_audio_agc_top.sv =====
// Per sample: emit waits for a free output register; one sample in flight at a time.
// Output register decouples the result: a new input beat is taken while a result waits.
// Frame end (every FRAME_LEN samples): history write, then the history max scan (one
// ring entry per cycle), a 23-step restoring gain divider, target clamp and gain update.
// Synchronous reset: gain 25.0, manual gain off, first frame returns zero samples.
module frame_peak_audio_agc_top #(
  parameter int unsigned FRAME_LEN   = 160,
  parameter int unsigned HISTORY_LEN = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        manual_gain,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample_out,
  output logic [15:0]        gain_used
);

  fpagc_pkg::fpagc_cmd_t cmd;
  fpagc_pkg::fpagc_sts_t sts;

  fpagc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpagc_dp #(
    .FRAME_LEN   (FRAME_LEN),
    .HISTORY_LEN (HISTORY_LEN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .manual_gain (manual_gain),
    .sample_in   (sample_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .gain_used   (gain_used)
  );

endmodule
